/* hw/rtl/kfrl_pkg.sv */
`default_nettype none

package kfrl_pkg;

    // Fixed field widths
    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 32;
    localparam int CAP_W    = 16;
    localparam int REASON_W = 16;
    localparam int COUNT_W  = 32;
    localparam int CAUSE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default fraction bits of the token level
    localparam int FRAC_BITS_DEF = 16;

    // Stream payload widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 56;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 2'd2;

    // Register reset values
    localparam logic [PERIOD_W-1:0] MIN_INTERVAL_RST  = 32'd0;
    localparam logic [PERIOD_W-1:0] REFILL_PERIOD_RST = 32'd1000000;
    localparam logic [CAP_W-1:0]    CAPACITY_RST      = 16'd1;

    // Reject causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_INTERVAL = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_NO_TOKEN = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic prep;
        logic mul;
        logic cmp;
        logic div_step;
        logic apply;
        logic decide;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic no_div;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/kfrl_ctrl.sv */
`default_nettype none

module kfrl_ctrl #(
    parameter int FRAC_BITS = kfrl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_kind,
    output logic                      o_in_ready,
    input  wire kfrl_pkg::t_dp_status i_status,
    output kfrl_pkg::t_dp_cmd         o_cmd
);

    localparam int QW    = kfrl_pkg::CAP_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_APPLY  = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_in_kind ? S_DECIDE : S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_cnt = CNT_LAST;
                n_state = i_status.no_div ? S_APPLY : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                // wait for a free output slot
                if (i_status.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Divider runs exactly QW steps
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_APPLY))
        else $error("divider did not hand over to apply after last step");

    // One item in flight: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is still in flight");

endmodule

`default_nettype wire

/* hw/rtl/kfrl_datapath.sv */
`default_nettype none

module kfrl_datapath #(
    parameter int FRAC_BITS = kfrl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [kfrl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [kfrl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [kfrl_pkg::IN_DATA_W-1:0]     i_in_data,
    input  wire logic                               i_in_kind,
    input  wire kfrl_pkg::t_dp_cmd                  i_cmd,
    output kfrl_pkg::t_dp_status                    o_status,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [kfrl_pkg::OUT_DATA_W-1:0]         o_out_data
);

    localparam int TW  = kfrl_pkg::CAP_W + FRAC_BITS;
    localparam int TMW = kfrl_pkg::TIME_W;
    localparam int PW  = kfrl_pkg::PERIOD_W;
    localparam int CW  = kfrl_pkg::CAP_W;
    localparam int RW  = kfrl_pkg::REASON_W;
    localparam int NW  = kfrl_pkg::COUNT_W;
    localparam int MW  = PW + CW;
    localparam logic [TW-1:0] ONE_TOK = TW'(1) << FRAC_BITS;

    // Configuration
    logic [PW-1:0] r_min, r_period;
    logic [CW-1:0] r_cap;

    // Bucket state
    logic [TW-1:0]  r_tok;
    logic [TMW-1:0] r_lrt, r_la;
    logic [NW-1:0]  r_rej;
    logic           r_pend;
    logic [RW-1:0]  r_code;

    // Work registers
    logic           r_kind;
    logic [RW-1:0]  r_reason;
    logic [TMW-1:0] r_now, r_elapsed;
    logic           r_skip;
    logic [MW-1:0]  r_prod;
    logic [PW-1:0]  r_rem;
    logic [TW-1:0]  r_quo;

    // Output register
    logic                             r_out_valid;
    logic                             r_out_acc;
    logic [kfrl_pkg::CAUSE_W-1:0]     r_out_cause;
    logic [NW-1:0]                    r_out_total;
    logic                             r_out_taken;
    logic [RW-1:0]                    r_out_reason;

    logic [CW-1:0]  cap_whole;
    logic [TW-1:0]  cap_q;
    logic [TMW-1:0] lrt_eff;
    logic           elapsed_ge;
    logic [PW:0]    trial, diff;
    logic           q_bit;
    logic [TW:0]    tok_sum;
    logic           interval_hit, no_token;
    logic [NW-1:0]  n_rej;
    logic           n_acc;
    logic [RW-1:0]  reason_fix;

    // Shared arithmetic
    always_comb begin
        cap_whole    = (r_cap == '0) ? CW'(1) : r_cap;
        cap_q        = {cap_whole, {FRAC_BITS{1'b0}}};
        lrt_eff      = (r_lrt == '0) ? r_now : r_lrt;
        elapsed_ge   = r_elapsed >= TMW'(r_prod);
        trial        = {r_rem, r_quo[TW-1]};
        diff         = trial - {1'b0, r_period};
        q_bit        = trial >= {1'b0, r_period};
        tok_sum      = {1'b0, r_tok} + {1'b0, r_quo};
        interval_hit = (r_la != '0) &&
                       ({1'b0, r_now} < ({1'b0, r_la} + (TMW + 1)'(r_min)));
        no_token     = r_tok < ONE_TOK;
        n_rej        = (r_rej != '1) ? (r_rej + 1'b1) : r_rej;
        n_acc        = !r_kind && !interval_hit && !no_token;
        reason_fix   = (r_reason == '0) ? RW'(1) : r_reason;
    end

    assign o_status.no_div   = r_skip || elapsed_ge;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= kfrl_pkg::MIN_INTERVAL_RST;
            r_period <= kfrl_pkg::REFILL_PERIOD_RST;
            r_cap    <= kfrl_pkg::CAPACITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kfrl_pkg::REG_MIN_INTERVAL:  r_min    <= i_cfg_data;
                kfrl_pkg::REG_REFILL_PERIOD: r_period <= i_cfg_data;
                kfrl_pkg::REG_CAPACITY:      r_cap    <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Bucket state: seed, refill, spend, count, latch and take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= {kfrl_pkg::CAPACITY_RST, {FRAC_BITS{1'b0}}};
            r_lrt  <= '0;
            r_la   <= '0;
            r_rej  <= '0;
            r_pend <= 1'b0;
            r_code <= '0;
        end else begin
            if (i_cmd.prep) begin
                r_lrt <= lrt_eff;
            end
            if (i_cmd.apply && r_quo != '0) begin
                r_tok <= (tok_sum > {1'b0, cap_q}) ? cap_q : tok_sum[TW-1:0];
                r_lrt <= r_now;
            end
            if (i_cmd.decide) begin
                if (r_kind) begin
                    r_pend <= 1'b0;
                end else if (interval_hit || no_token) begin
                    r_rej <= n_rej;
                end else begin
                    r_tok  <= r_tok - ONE_TOK;
                    r_la   <= r_now;
                    r_code <= reason_fix;
                    r_pend <= 1'b1;
                end
            end
        end
    end

    // Capture, elapsed time, product and serial divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_in_kind;
            r_reason <= i_in_data[RW-1:0];
            r_now    <= i_in_data[RW +: TMW];
        end
        if (i_cmd.prep) begin
            r_elapsed <= r_now - lrt_eff;
            r_skip    <= (r_now <= lrt_eff) || (r_period == '0);
        end
        if (i_cmd.mul) begin
            r_prod <= MW'(cap_whole) * MW'(r_period);
        end
        if (i_cmd.cmp) begin
            if (r_skip) begin
                r_quo <= '0;
            end else if (elapsed_ge) begin
                r_quo <= cap_q;
            end else begin
                // quotient of (elapsed << FRAC_BITS) / period fits TW bits
                r_rem <= r_elapsed[MW-1:CW];
                r_quo <= {r_elapsed[CW-1:0], {FRAC_BITS{1'b0}}};
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? diff[PW-1:0] : trial[PW-1:0];
            r_quo <= {r_quo[TW-2:0], q_bit};
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_out_acc    <= n_acc;
            r_out_taken  <= r_kind && r_pend;
            r_out_reason <= (r_kind && r_pend) ? r_code : '0;
            if (r_kind) begin
                r_out_cause <= kfrl_pkg::CAUSE_NONE;
                r_out_total <= r_rej;
            end else if (interval_hit) begin
                r_out_cause <= kfrl_pkg::CAUSE_INTERVAL;
                r_out_total <= n_rej;
            end else if (no_token) begin
                r_out_cause <= kfrl_pkg::CAUSE_NO_TOKEN;
                r_out_total <= n_rej;
            end else begin
                r_out_cause <= kfrl_pkg::CAUSE_NONE;
                r_out_total <= r_rej;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {4'b0, r_out_reason, r_out_taken, r_out_total,
                          r_out_cause, r_out_acc};

    // An accepted request leaves a pending request behind
    a_accept_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && n_acc) |=> (r_pend && r_out_acc))
        else $error("accepted request not latched as pending");

    // A result never both accepts and takes, and an accept has no cause
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!(r_out_acc && r_out_taken) &&
                         (!r_out_acc || r_out_cause == kfrl_pkg::CAUSE_NONE)))
        else $error("inconsistent result fields");

endmodule

`default_nettype wire

/* hw/rtl/keyframe_request_rate_limiter_core.sv */
`default_nettype none

// Token bucket limiter for keyframe requests. Each input transfer is either a
// request (tuser = 0) carrying a reason and a microsecond timestamp, or a take
// of the pending request (tuser = 1); every input transfer yields exactly one
// result transfer. A request refills the bucket by elapsed / refill period in
// Q16.16 (FRAC_BITS fraction bits), capped at the capacity, then is checked
// against the minimum interval and for one whole token. Items are handled one
// at a time: a take goes from capture to decide; a request that needs no divide
// (first request, no time passed, refill disabled or bucket refilled to full)
// runs prep, multiply, compare, apply and decide; any other request also runs
// the bit-serial restoring divider, one quotient bit a cycle, before apply. A
// result waits in an output register, so a stalled output side only holds the
// block at the final step of an item. The user must write registers through
// i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the block does not enforce it.
module keyframe_request_rate_limiter_core #(
    parameter int FRAC_BITS = kfrl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [kfrl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [kfrl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] req_reason, [79:16] now_us
    input  wire logic [kfrl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  wire logic [0:0]                      s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] accepted, [2:1] reject_cause, [34:3] reject_total, [35] taken,
    // [51:36] taken_reason, [55:52] zero
    output logic [kfrl_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    kfrl_pkg::t_dp_cmd    cmd;
    kfrl_pkg::t_dp_status status;

    kfrl_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kfrl_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser[0]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
